FILE: hw/rtl/dkc_pkg.sv
package dkc_pkg;

    localparam int KEY_W      = 48;
    localparam int SLOT_OUT_W = 8;
    localparam int TOTAL_W    = 32;

    localparam logic OP_CLEAR = 1'b1;

    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_INSERT   = 2'd1;
    localparam logic [1:0] ST_UNCACHED = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [15:0] az_code;
        logic [15:0] el_code;
        logic [15:0] width_code;
    } t_cmd;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  evicted;
        logic [SLOT_OUT_W-1:0] evicted_slot;
        logic [TOTAL_W-1:0]    hit_total;
        logic [TOTAL_W-1:0]    miss_total;
    } t_result;

    typedef struct packed {
        logic load;
        logic clr_regs;
        logic clr_step;
        logic probe_init;
        logic probe_next;
        logic set_hit;
        logic set_uncached;
        logic evict;
        logic insert;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic match;
        logic empty;
        logic probe_last;
        logic ring_full;
        logic clr_last;
    } t_dp_sts;

endpackage

FILE: hw/rtl/direction_key_cache_fifo_evict.sv
// Slot manager for a direction-keyed cache: linear probing from the key's home
// slot, FIFO eviction of the oldest inserted slot, saturating hit/miss totals.
// A word is taken when start is high and busy is low; its result appears on
// o_result for exactly one cycle with o_done high, and must be taken then, as
// the block cannot be held off. A lookup word passes through the hash states,
// then one read of the key memory and one compare for every slot probed, then,
// on finding an empty slot, an eviction if the ring is full and an insert.
// A clear empties the key memory, one key memory entry a cycle. After reset
// the block stays busy while it empties the key memory, and gives no result
// for that pass.
module direction_key_cache_fifo_evict #(
    parameter int TABLE_SLOTS = 256,
    parameter int RING_DEPTH  = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dkc_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output dkc_pkg::t_result o_result
);
    import dkc_pkg::*;

    t_dp_cmd ctl;
    t_dp_sts sts;

    dkc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_cmd.operation),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (ctl)
    );

    dkc_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .RING_DEPTH  (RING_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

FILE: hw/rtl/dkc_ctrl.sv
module dkc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_op,
    output logic             busy,
    input  dkc_pkg::t_dp_sts i_sts,
    output dkc_pkg::t_dp_cmd o_cmd
);
    import dkc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_CLEAR   = 11'b000_0000_0010,
        S_HASH1   = 11'b000_0000_0100,
        S_HASH2   = 11'b000_0000_1000,
        S_HASH3   = 11'b000_0001_0000,
        S_HASH4   = 11'b000_0010_0000,
        S_READ    = 11'b000_0100_0000,
        S_COMPARE = 11'b000_1000_0000,
        S_EVICT   = 11'b001_0000_0000,
        S_INSERT  = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_report, n_report;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_report = r_report;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_op == OP_CLEAR) begin
                        o_cmd.clr_regs = 1'b1;
                        n_report       = 1'b1;
                        n_state        = S_CLEAR;
                    end else begin
                        n_state = S_HASH1;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_report = 1'b0;
                    n_state  = r_report ? S_DONE : S_IDLE;
                end
            end
            S_HASH1: n_state = S_HASH2;
            S_HASH2: n_state = S_HASH3;
            S_HASH3: n_state = S_HASH4;
            S_HASH4: begin
                o_cmd.probe_init = 1'b1;
                n_state          = S_READ;
            end
            S_READ: n_state = S_COMPARE;
            S_COMPARE: begin
                if (i_sts.match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.empty) begin
                    n_state = i_sts.ring_full ? S_EVICT : S_INSERT;
                end else if (i_sts.probe_last) begin
                    o_cmd.set_uncached = 1'b1;
                    n_state            = S_DONE;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_READ;
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_INSERT;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
        end
    end

endmodule

FILE: hw/rtl/dkc_dp.sv
module dkc_dp #(
    parameter int TABLE_SLOTS = 256,
    parameter int RING_DEPTH  = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dkc_pkg::t_cmd    i_cmd,
    input  dkc_pkg::t_dp_cmd i_ctl,
    output dkc_pkg::t_dp_sts o_sts,
    output logic             o_done,
    output dkc_pkg::t_result o_result
);
    import dkc_pkg::*;

    localparam int TW    = $clog2(TABLE_SLOTS);
    localparam int RW    = $clog2(RING_DEPTH);
    localparam int FW    = $clog2(RING_DEPTH + 1);
    localparam int Q_W   = 18;
    localparam int SUM_W = TW + Q_W;
    localparam int ENT_W = KEY_W + 1;

    localparam logic [TW-1:0]    K32    = TW'((64'd1 << 32) % TABLE_SLOTS);
    localparam logic [TW-1:0]    K16    = TW'((64'd1 << 16) % TABLE_SLOTS);
    localparam logic [SUM_W-1:0] RECIP  = SUM_W'((64'd1 << SUM_W) / TABLE_SLOTS);
    localparam logic [TW:0]      T_V    = (TW+1)'(TABLE_SLOTS);
    localparam logic [TW-1:0]    T_LAST = TW'(TABLE_SLOTS - 1);
    localparam logic [RW-1:0]    R_LAST = RW'(RING_DEPTH - 1);
    localparam logic [FW-1:0]    R_FULL = FW'(RING_DEPTH);
    localparam logic [ENT_W-1:0] EMPTY  = {ENT_W{1'b1}};

    logic [ENT_W-1:0]   r_keys_mem [TABLE_SLOTS];
    logic [TW-1:0]      r_ring_mem [RING_DEPTH];

    logic [KEY_W-1:0]   r_key;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [2*SUM_W-1:0] r_prod, n_prod;
    logic [SUM_W-1:0]   r_qt;
    logic [Q_W-1:0]     quot;
    logic [SUM_W:0]     qt_full;
    logic [SUM_W-1:0]   diff;
    logic [TW:0]        rem;
    logic [TW-1:0]      n_probe_init;
    logic [TW-1:0]      r_probe, r_pcnt;
    logic [ENT_W-1:0]   r_entry;
    logic [TW-1:0]      r_victim;

    logic [RW-1:0]      r_head, r_tail;
    logic [FW-1:0]      r_fill;
    logic [TOTAL_W-1:0] r_hits, r_misses;
    logic [TW-1:0]      r_clr_idx;
    logic               r_done;

    logic [1:0]         r_status;
    logic [TW-1:0]      r_slot, r_ev_slot;
    logic               r_ev;
    t_result            r_result;

    logic               key_we;
    logic [TW-1:0]      key_wa;
    logic [ENT_W-1:0]   key_wd;

    assign n_sum  = SUM_W'(r_key[47:32]) * SUM_W'(K32)
                  + SUM_W'(r_key[31:16]) * SUM_W'(K16)
                  + SUM_W'(r_key[15:0]);
    assign n_prod = (2*SUM_W)'(r_sum) * (2*SUM_W)'(RECIP);
    assign quot    = r_prod[SUM_W +: Q_W];
    assign qt_full = (SUM_W+1)'(quot) * (SUM_W+1)'(T_V);
    assign diff    = r_sum - r_qt;
    assign rem     = diff[TW:0];
    assign n_probe_init = (rem >= T_V) ? TW'(rem - T_V) : rem[TW-1:0];

    assign key_we = i_ctl.clr_step | i_ctl.evict | i_ctl.insert;
    assign key_wd = i_ctl.insert ? {1'b0, r_key} : EMPTY;

    always_comb begin
        key_wa = r_clr_idx;
        if (i_ctl.evict) begin
            key_wa = r_victim;
        end else if (i_ctl.insert) begin
            key_wa = r_probe;
        end
    end

    assign o_sts.match      = (r_entry == {1'b0, r_key});
    assign o_sts.empty      = r_entry[ENT_W-1];
    assign o_sts.probe_last = (r_pcnt == T_LAST);
    assign o_sts.ring_full  = (r_fill == R_FULL);
    assign o_sts.clr_last   = (r_clr_idx == T_LAST);

    assign o_done   = r_done;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_keys_mem[key_wa] <= key_wd;
        end
        r_entry <= r_keys_mem[r_probe];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_ring_mem[r_tail] <= r_probe;
        end
        r_victim <= r_ring_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_prod <= n_prod;
        r_qt   <= qt_full[SUM_W-1:0];
        if (i_ctl.load) begin
            r_key     <= {i_cmd.az_code, i_cmd.el_code, i_cmd.width_code};
            r_slot    <= '0;
            r_ev      <= 1'b0;
            r_ev_slot <= '0;
        end
        if (i_ctl.clr_regs) begin
            r_status <= ST_CLEARED;
        end
        if (i_ctl.probe_init) begin
            r_probe <= n_probe_init;
            r_pcnt  <= '0;
        end
        if (i_ctl.probe_next) begin
            r_probe <= (r_probe == T_LAST) ? '0 : r_probe + 1'b1;
            r_pcnt  <= r_pcnt + 1'b1;
        end
        if (i_ctl.set_hit) begin
            r_status <= ST_HIT;
            r_slot   <= r_probe;
        end
        if (i_ctl.set_uncached) begin
            r_status <= ST_UNCACHED;
        end
        if (i_ctl.evict) begin
            r_ev      <= 1'b1;
            r_ev_slot <= r_victim;
        end
        if (i_ctl.insert) begin
            r_status <= ST_INSERT;
            r_slot   <= r_probe;
        end
        if (i_ctl.emit) begin
            r_result.status       <= r_status;
            r_result.slot_index   <= SLOT_OUT_W'(r_slot);
            r_result.evicted      <= r_ev;
            r_result.evicted_slot <= SLOT_OUT_W'(r_ev_slot);
            r_result.hit_total    <= r_hits;
            r_result.miss_total   <= r_misses;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_clr_idx <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_ctl.emit;
            if (i_ctl.clr_regs) begin
                r_head    <= '0;
                r_tail    <= '0;
                r_fill    <= '0;
                r_hits    <= '0;
                r_misses  <= '0;
                r_clr_idx <= '0;
            end
            if (i_ctl.clr_step) begin
                r_clr_idx <= (r_clr_idx == T_LAST) ? '0 : r_clr_idx + 1'b1;
            end
            if (i_ctl.set_hit && r_hits != '1) begin
                r_hits <= r_hits + 1'b1;
            end
            if ((i_ctl.set_uncached || i_ctl.insert) && r_misses != '1) begin
                r_misses <= r_misses + 1'b1;
            end
            if (i_ctl.evict) begin
                r_head <= (r_head == R_LAST) ? '0 : r_head + 1'b1;
                r_fill <= r_fill - 1'b1;
            end
            if (i_ctl.insert) begin
                r_tail <= (r_tail == R_LAST) ? '0 : r_tail + 1'b1;
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= R_FULL)
        else $error("ring fill beyond depth");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.evict |-> r_fill == R_FULL)
        else $error("eviction with ring not full");

    a_insert_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.insert |-> r_entry[ENT_W-1])
        else $error("insert over an occupied slot");

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.probe_init |=> r_probe < T_V)
        else $error("home slot out of range");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done strobe longer than one cycle");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import dkc_pkg::*;

    localparam int NSLOTS       = 256;
    localparam int RING         = 128;
    localparam int RANDOM_WORDS = 2000;
    localparam int POOL         = 160;
    localparam int DRAIN_CYCLES = 600;
    localparam int LIMIT_CYCLES = 5_000_000;
    localparam logic [63:0] EMPTY_KEY = '1;

    class slot_tracker;
        logic [63:0] slot_keys [NSLOTS];
        int unsigned ring_slots [RING];
        int unsigned ring_head;
        int unsigned fill;
        int unsigned hit_count;
        int unsigned miss_count;
        t_result     awaited [$];
        int unsigned errors;

        function new();
            wipe();
            errors = 0;
        endfunction

        function void wipe();
            foreach (slot_keys[i]) slot_keys[i] = EMPTY_KEY;
            foreach (ring_slots[i]) ring_slots[i] = 0;
            ring_head  = 0;
            fill       = 0;
            hit_count  = 0;
            miss_count = 0;
        endfunction

        function int unsigned saturate_up(int unsigned v);
            return (v == 32'hFFFF_FFFF) ? v : v + 1;
        endfunction

        function void note_word(t_cmd c);
            t_result     r;
            logic [63:0] key;
            int unsigned probe;
            int unsigned victim;
            r = '0;
            if (c.operation == OP_CLEAR) begin
                wipe();
                r.status = ST_CLEARED;
            end else begin
                key      = {16'h0000, c.az_code, c.el_code, c.width_code};
                probe    = 32'(key % NSLOTS);
                r.status = ST_UNCACHED;
                for (int i = 0; i < NSLOTS; i++) begin
                    if (slot_keys[probe] == key) begin
                        hit_count    = saturate_up(hit_count);
                        r.status     = ST_HIT;
                        r.slot_index = 8'(probe);
                        break;
                    end
                    if (slot_keys[probe] == EMPTY_KEY) begin
                        miss_count = saturate_up(miss_count);
                        if (fill >= RING) begin
                            victim = ring_slots[ring_head];
                            if (victim < NSLOTS) slot_keys[victim] = EMPTY_KEY;
                            r.evicted      = 1'b1;
                            r.evicted_slot = 8'(victim);
                            ring_head      = (ring_head + 1) % RING;
                            fill--;
                        end
                        slot_keys[probe] = key;
                        ring_slots[(ring_head + fill) % RING] = probe;
                        fill++;
                        r.status     = ST_INSERT;
                        r.slot_index = 8'(probe);
                        break;
                    end
                    probe = (probe + 1) % NSLOTS;
                end
                if (r.status == ST_UNCACHED) miss_count = saturate_up(miss_count);
            end
            r.hit_total  = hit_count;
            r.miss_total = miss_count;
            awaited.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: %p", got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.slot_index !== want.slot_index ||
                got.evicted !== want.evicted || got.evicted_slot !== want.evicted_slot ||
                got.hit_total !== want.hit_total || got.miss_total !== want.miss_total) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: want st=%0d slot=%0d ev=%0d evs=%0d hits=%0d misses=%0d",
                             want.status, want.slot_index, want.evicted, want.evicted_slot,
                             want.hit_total, want.miss_total);
                    $display("          got  st=%0d slot=%0d ev=%0d evs=%0d hits=%0d misses=%0d",
                             got.status, got.slot_index, got.evicted, got.evicted_slot,
                             got.hit_total, got.miss_total);
                end
            end
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_cmd        cmd_word = '0;
    logic        o_done;
    t_result     o_result;
    int unsigned cycle_count = 0;
    slot_tracker tracker;
    t_cmd        key_pool [POOL];

    direction_key_cache_fifo_evict #(
        .TABLE_SLOTS(NSLOTS),
        .RING_DEPTH (RING)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd_word),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[direction_key_cache_fifo_evict] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) tracker.check_result(o_result);
    end

    function automatic t_cmd lookup(logic [15:0] az, logic [15:0] el, logic [15:0] wd);
        t_cmd c;
        c.operation  = ~OP_CLEAR;
        c.az_code    = az;
        c.el_code    = el;
        c.width_code = wd;
        return c;
    endfunction

    function automatic t_cmd random_cmd(logic op);
        t_cmd c;
        c.operation  = op;
        c.az_code    = 16'($urandom);
        c.el_code    = 16'($urandom);
        c.width_code = 16'($urandom);
        return c;
    endfunction

    // cluster pool keys near a random base slot to build long probe chains
    task automatic refill_pool();
        int         span;
        logic [7:0] base;
        case ($urandom_range(0, 3))
            0: span = 0;
            1: span = 7;
            2: span = 63;
            default: span = 255;
        endcase
        base = 8'($urandom);
        foreach (key_pool[i]) begin
            key_pool[i] = random_cmd(~OP_CLEAR);
            key_pool[i].width_code[7:0] = base + 8'($urandom_range(0, span));
        end
    endtask

    task automatic send_word(input t_cmd c, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        cmd_word <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.note_word(c);
    endtask

    initial begin
        t_cmd c;
        bit   quiet;
        int   roll;
        tracker = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        c = random_cmd(OP_CLEAR);
        send_word(c, 1'b0);
        send_word(lookup(16'h0000, 16'h0000, 16'h0000), 1'b0);
        send_word(lookup(16'h0000, 16'h0000, 16'h0000), 1'b0);
        send_word(lookup(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
        send_word(lookup(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        // wrap the probe from the last slot round to the first
        send_word(lookup(16'h0001, 16'h0000, 16'h00FF), 1'b0);
        send_word(lookup(16'hFFFF, 16'hFFFF, 16'h0000), 1'b1);
        send_word(lookup(16'hAAAA, 16'h5555, 16'hAAAA), 1'b0);
        send_word(lookup(16'h5555, 16'hAAAA, 16'h5555), 1'b0);
        send_word(lookup(16'h0000, 16'h0000, 16'h0000), 1'b0);
        send_word(lookup(16'h0001, 16'h0000, 16'h00FF), 1'b0);
        c = lookup(16'hFFFF, 16'hFFFF, 16'hFFFF);
        c.operation = OP_CLEAR;
        send_word(c, 1'b0);
        send_word(lookup(16'h0000, 16'h0000, 16'h0000), 1'b0);
        send_word(lookup(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_word(lookup(16'h0000, 16'h0000, 16'h0000), 1'b1);
        c = lookup(16'h0000, 16'h0000, 16'h0000);
        c.operation = OP_CLEAR;
        send_word(c, 1'b0);

        refill_pool();
        quiet = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 999);
            if (roll < 4)
                c = random_cmd(OP_CLEAR);
            else if (roll < 700)
                c = key_pool[$urandom_range(0, POOL - 1)];
            else
                c = random_cmd(~OP_CLEAR);
            send_word(c, quiet);
            if (c.operation == OP_CLEAR) refill_pool();
        end
        start <= 1'b0;

        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
            $display("[direction_key_cache_fifo_evict] OK");
        end else begin
            $display("[direction_key_cache_fifo_evict] ERROR");
        end
        $finish;
    end
endmodule

FILE: direction_key_cache_fifo_evict.f
hw/rtl/dkc_pkg.sv
hw/rtl/dkc_ctrl.sv
hw/rtl/dkc_dp.sv
hw/rtl/direction_key_cache_fifo_evict.sv
verif/tb_top.sv
